### sv/ctcs_pkg.sv
// ----------------------------------------------------------------------------
// ctcs_pkg: shared definitions for the two-congruence CRT solver
// Field widths and sequencer state encoding.
// ----------------------------------------------------------------------------
package ctcs_pkg;

    localparam int MODULUS_BITS = 31;
    localparam int MB           = MODULUS_BITS;
    localparam int WIDE         = 2 * MB;
    localparam int CNT_W        = $clog2(WIDE + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_RA,
        ST_RB,
        ST_EU_MUL,
        ST_EU_UPD,
        ST_RAM,
        ST_DG,
        ST_MR,
        ST_INV,
        ST_T,
        ST_TR,
        ST_SOL,
        ST_LCM,
        ST_OUT
    } state_t;

endpackage

### sv/two_congruence_crt_solver.sv
// ----------------------------------------------------------------------------
// two_congruence_crt_solver: combine x = a mod n and x = b mod m
// Extended Euclid over one shared shift-subtract divider and one multiplier.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The block takes a new beat only when idle. All
// division goes through one restoring divider that retires one quotient bit
// per cycle, for a 31-bit dividend or for the 62-bit reduction; each Euclid
// step is a division plus the cofactor update (ST_EU_MUL, then ST_EU_UPD).
// An item takes at most about 45 Euclid steps for 31-bit moduli. A zero
// modulus answers with all fields zero; found = 0 means no common solution.
module two_congruence_crt_solver
    import ctcs_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [MB-1:0]   s_residue_a,
    input  logic [MB-1:0]   s_residue_b,
    input  logic [MB-1:0]   s_modulus_n,
    input  logic [MB-1:0]   s_modulus_m,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_found,
    output logic [WIDE-1:0] m_solution,
    output logic [WIDE-1:0] m_period
);

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [MB-1:0]   a_reg, b_reg, n_reg, m_reg;
    logic [MB-1:0]   a_next, b_next, n_next, m_next;
    logic [MB-1:0]   ra_reg, rb_reg, ra_next, rb_next;
    logic [MB-1:0]   pr_reg, cr_reg, pr_next, cr_next;
    logic signed [MB+1:0] ps_reg, cs_reg, ps_next, cs_next;
    logic [MB-1:0]   dq_reg, mr_reg, dq_next, mr_next;
    logic            found_reg, found_next;
    logic [WIDE-1:0] sol_reg, per_reg, sol_next, per_next;

    // divider
    logic [WIDE-1:0] dvd_reg, quo_reg;
    logic [MB-1:0]   dsr_reg;
    logic [MB:0]     rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic            div_start, div_long;
    logic [WIDE-1:0] div_x;
    logic [MB-1:0]   div_y;
    logic [MB+1:0]   trial;

    // multiplier
    logic signed [MB+1:0]       mul_a, mul_b;
    logic signed [2*MB+3:0]     prod_reg;

    logic [MB-1:0]   s_abs, inv_val, rem_lo;
    logic            accept;

    assign accept = s_valid && s_ready;
    assign rem_lo = rem_reg[MB-1:0];
    assign trial  = {1'b0, rem_reg[MB-1:0], dvd_reg[WIDE-1]} - {2'b00, dsr_reg};
    assign s_abs  = ps_reg[MB+1] ? MB'(-ps_reg) : ps_reg[MB-1:0];
    assign inv_val = (ps_reg[MB+1] && rem_lo != '0) ? mr_reg - rem_lo : rem_lo;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_modulus_n == '0 || s_modulus_m == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ret_reg;
                end
            end
            ST_RA:     state_next = ST_DIV;
            ST_RB:     state_next = ST_DIV;
            ST_EU_MUL: state_next = ST_EU_UPD;
            ST_EU_UPD: state_next = ST_DIV;
            ST_RAM:    state_next = ST_DIV;
            ST_DG: begin
                state_next = (rem_lo != '0) ? ST_OUT : ST_DIV;
            end
            ST_MR:     state_next = ST_DIV;
            ST_INV:    state_next = ST_T;
            ST_T:      state_next = ST_DIV;
            ST_TR:     state_next = ST_SOL;
            ST_SOL:    state_next = ST_LCM;
            ST_LCM:    state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        ret_next   = ret_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        pr_next    = pr_reg;
        cr_next    = cr_reg;
        ps_next    = ps_reg;
        cs_next    = cs_reg;
        dq_next    = dq_reg;
        mr_next    = mr_reg;
        found_next = found_reg;
        sol_next   = sol_reg;
        per_next   = per_reg;
        div_start  = 1'b0;
        div_long   = 1'b0;
        div_x      = '0;
        div_y      = '0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                a_next     = s_residue_a;
                b_next     = s_residue_b;
                n_next     = s_modulus_n;
                m_next     = s_modulus_m;
                found_next = 1'b0;
                sol_next   = '0;
                per_next   = '0;
                div_start  = accept;
                div_x      = WIDE'(s_residue_a);
                div_y      = s_modulus_n;
                ret_next   = ST_RA;
            end
            ST_RA: begin
                ra_next   = rem_lo;
                div_start = 1'b1;
                div_x     = WIDE'(b_reg);
                div_y     = m_reg;
                ret_next  = ST_RB;
            end
            ST_RB: begin
                rb_next   = rem_lo;
                pr_next   = n_reg;
                cr_next   = m_reg;
                ps_next   = (MB+2)'(1);
                cs_next   = '0;
                div_start = 1'b1;
                div_x     = WIDE'(n_reg);
                div_y     = m_reg;
                ret_next  = ST_EU_MUL;
            end
            ST_EU_MUL: begin
                mul_a = {2'b00, quo_reg[MB-1:0]};
                mul_b = cs_reg;
            end
            ST_EU_UPD: begin
                pr_next = cr_reg;
                cr_next = rem_lo;
                ps_next = cs_reg;
                cs_next = ps_reg - prod_reg[MB+1:0];
                div_start = 1'b1;
                if (rem_lo == '0) begin
                    div_x    = WIDE'(ra_reg);
                    div_y    = m_reg;
                    ret_next = ST_RAM;
                end else begin
                    div_x    = WIDE'(cr_reg);
                    div_y    = rem_lo;
                    ret_next = ST_EU_MUL;
                end
            end
            ST_RAM: begin
                // (rb + m - ra mod m) lies in [1, 2m)
                div_start = 1'b1;
                div_x = WIDE'(({1'b0, rb_reg} + {1'b0, m_reg} - {1'b0, rem_lo})
                    >= {1'b0, m_reg}
                    ? ({1'b0, rb_reg} - {1'b0, rem_lo})
                    : ({1'b0, rb_reg} + {1'b0, m_reg} - {1'b0, rem_lo}));
                div_y    = pr_reg;
                ret_next = ST_DG;
            end
            ST_DG: begin
                dq_next   = quo_reg[MB-1:0];
                div_start = (rem_lo == '0);
                div_x     = WIDE'(m_reg);
                div_y     = pr_reg;
                ret_next  = ST_MR;
            end
            ST_MR: begin
                mr_next   = quo_reg[MB-1:0];
                div_start = 1'b1;
                div_x     = WIDE'(s_abs);
                div_y     = quo_reg[MB-1:0];
                ret_next  = ST_INV;
            end
            ST_INV: begin
                mul_a = {2'b00, dq_reg};
                mul_b = {2'b00, inv_val};
            end
            ST_T: begin
                div_start = 1'b1;
                div_long  = 1'b1;
                div_x     = prod_reg[WIDE-1:0];
                div_y     = mr_reg;
                ret_next  = ST_TR;
            end
            ST_TR: begin
                mul_a = {2'b00, n_reg};
                mul_b = {2'b00, rem_lo};
            end
            ST_SOL: begin
                sol_next = WIDE'(ra_reg) + prod_reg[WIDE-1:0];
                mul_a    = {2'b00, n_reg};
                mul_b    = {2'b00, mr_reg};
            end
            ST_LCM: begin
                per_next   = prod_reg[WIDE-1:0];
                found_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (div_start) begin
                cnt_reg <= div_long ? CNT_W'(WIDE) : CNT_W'(MB);
            end else if (state_reg == ST_DIV) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        n_reg     <= n_next;
        m_reg     <= m_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        pr_reg    <= pr_next;
        cr_reg    <= cr_next;
        ps_reg    <= ps_next;
        cs_reg    <= cs_next;
        dq_reg    <= dq_next;
        mr_reg    <= mr_next;
        found_reg <= found_next;
        sol_reg   <= sol_next;
        per_reg   <= per_next;
        prod_reg  <= mul_a * mul_b;
        if (div_start) begin
            dvd_reg <= div_long ? div_x : {div_x[MB-1:0], MB'(0)};
            dsr_reg <= div_y;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            dvd_reg <= {dvd_reg[WIDE-2:0], 1'b0};
            if (!trial[MB+1]) begin
                rem_reg <= trial[MB:0];
                quo_reg <= {quo_reg[WIDE-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[MB-1:0], dvd_reg[WIDE-1]};
                quo_reg <= {quo_reg[WIDE-2:0], 1'b0};
            end
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_OUT);
    assign m_found    = found_reg;
    assign m_solution = sol_reg;
    assign m_period   = per_reg;

    a_no_sol_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_solution == '0 && m_period == '0)
        else $error("no-solution beat carries nonzero fields");

    a_sol_below_period: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_solution < m_period)
        else $error("solution not below period");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg != '0)
        else $error("divider running with zero count");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_solution) && $stable(m_period))
        else $error("result beat changed while stalled");

endmodule
